// File: rtl/progressive_caesar_codec_macros.svh
// ----------------------------------------------------------------------------
// Progressive Caesar codec assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PROGRESSIVE_CAESAR_CODEC_MACROS_SVH
`define PROGRESSIVE_CAESAR_CODEC_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcc assertion failed");

// Check that cons holds in the cycle after ante
`define PCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcc assertion failed");

`endif

// File: rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, codes and character helpers of the progressive Caesar codec.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] CFG_MODE = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_KEY  = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_CAP  = 2'd2;

  // Mode codes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned KeyW    = 5;
  localparam int unsigned PosW    = 5;

  // Marker and lookahead
  localparam int unsigned MarkLen   = 7;
  localparam int unsigned LookLen   = 6;
  localparam int unsigned MarkIdxW  = 3;
  localparam int unsigned FillW     = 3;
  localparam logic [CharW-1:0] TERM_CHAR = 8'h00;
  localparam logic [KeyW-1:0]  ALPHA_LEN = 5'd26;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SMALL   = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BURST_IDLE,
    BURST_MARK,
    BURST_FLUSH
  } burst_e;

  // Character of the end-of-message marker at a given place
  function automatic logic [CharW-1:0] mark_char(input logic [MarkIdxW-1:0] idx);
    logic [CharW-1:0] ch;
    unique case (idx)
      3'd2:    ch = 8'h45;  // E
      3'd3:    ch = 8'h4F;  // O
      3'd4:    ch = 8'h4D;  // M
      3'd7:    ch = TERM_CHAR;
      default: ch = 8'h5F;  // underscore
    endcase
    return ch;
  endfunction

  // Shift a letter forward by amt (below 26), keeping its case
  function automatic logic [CharW-1:0] rotate_letter(input logic [CharW-1:0] c,
                                                     input logic [PosW-1:0]  amt);
    logic             is_lower;
    logic             is_upper;
    logic [CharW-1:0] base;
    logic [CharW-1:0] offs;
    logic [PosW:0]    sum;
    logic [PosW:0]    wrapped;
    is_lower = (c >= 8'h61) && (c <= 8'h7A);
    is_upper = (c >= 8'h41) && (c <= 8'h5A);
    base     = is_lower ? 8'h61 : 8'h41;
    offs     = c - base;
    sum      = {1'b0, offs[PosW-1:0]} + {1'b0, amt};
    wrapped  = (sum >= {1'b0, ALPHA_LEN}) ? (sum - {1'b0, ALPHA_LEN}) : sum;
    if (is_lower || is_upper) begin
      return base + {3'b000, wrapped[PosW-1:0]};
    end
    return c;
  endfunction

endpackage

// File: rtl/progressive_caesar_codec.sv
// ----------------------------------------------------------------------------
// progressive_caesar_codec
// Streaming letter-shift encoder and decoder with end-of-message marker.
// ----------------------------------------------------------------------------
// Takes one byte per item and shifts letters by key plus position modulo 26.
// An item is held in the input register and resolved in one pass into the
// result register, so items that give at most one result flow at one item
// per cycle. An end-of-text item gives a burst of results from the same
// result register, one per cycle: eight in encrypt mode (seven marker bytes
// and the terminator, or only the terminator on a too-small capacity), and
// in decrypt mode the held lookahead bytes, up to six, plus the terminator;
// the input register holds the next item during the burst. Results leave as
// long as the sink takes them; either side may stall at any time.
module progressive_caesar_codec #(
  parameter int unsigned MAX_MESSAGE = 65535
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pcc_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_in
  input  logic                          s_axis_tlast,   // end_of_text
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // [7:0] char_out, [23:8] count
  output logic                          m_axis_tlast,   // last
  output logic [1:0]                    m_axis_tuser    // [1:0] status
);
  import pcc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned RW = (CW > CountW) ? CW : CountW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_MESSAGE);
  localparam logic [RW-1:0] ShownMax = RW'({CountW{1'b1}});
  localparam logic [CountW-1:0] MarkLen16 = CountW'(MarkLen);

  // Configuration registers
  logic                mode_q;
  logic [KeyW-1:0]     key_q;
  logic [CountW-1:0]   cap_q;

  // Input register
  logic                in_valid_q, in_valid_d;
  logic [CharW-1:0]    in_char_q;
  logic                in_eot_q;

  // Message state
  logic [CW-1:0]       byte_count_q, byte_count_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                seen_q, seen_d;
  logic [CharW-1:0]    la_q [LookLen];

  // Burst sequencer
  burst_e              state_q, state_d;
  logic [MarkIdxW-1:0] mark_idx_q, mark_idx_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    out_char_q;
  logic                out_last_q;
  status_e             out_status_q;
  logic [CountW-1:0]   out_count_q;

  // Per-cycle controls
  logic                in_take;
  logic                can_load;
  logic                emit;
  logic [CharW-1:0]    e_char;
  logic                e_last;
  status_e             e_status;
  logic [CountW-1:0]   e_count;
  logic                do_adv;
  logic                do_clear;
  logic                la_shift;
  logic                la_wr;

  // Derived values
  logic [KeyW-1:0]     key_mod;
  logic [PosW:0]       fwd_sum;
  logic [PosW-1:0]     fwd_amt;
  logic [PosW-1:0]     bwd_amt;
  logic [RW-1:0]       count_ext;
  logic [CountW-1:0]   shown;
  logic                cap_small;
  logic [CountW-1:0]   room;
  logic                payload_full;
  logic                mark_match;
  logic [CharW-1:0]    dec_head;

  // Configuration port always takes writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENC;
      key_q  <= '0;
      cap_q  <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_MODE: mode_q <= cfg_data_i[0];
        CFG_KEY:  key_q  <= cfg_data_i[KeyW-1:0];
        CFG_CAP:  cap_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Shift amounts for the current position
  assign key_mod = (key_q >= ALPHA_LEN) ? (key_q - ALPHA_LEN) : key_q;
  assign fwd_sum = {1'b0, key_mod} + {1'b0, pos_q};
  assign fwd_amt = (fwd_sum >= {1'b0, ALPHA_LEN}) ? PosW'(fwd_sum - {1'b0, ALPHA_LEN})
                                                    : fwd_sum[PosW-1:0];
  assign bwd_amt = (fwd_amt == '0) ? '0 : (ALPHA_LEN - fwd_amt);

  // Reported count, capped to the field width
  assign count_ext = RW'(byte_count_q);
  assign shown     = (count_ext > ShownMax) ? '1 : count_ext[CountW-1:0];

  // Encrypt payload room
  assign cap_small    = cap_q < MarkLen16;
  assign room         = cap_q - MarkLen16;
  assign payload_full = (count_ext >= RW'(room)) || (byte_count_q == MaxCnt);

  // Marker search over the lookahead and the incoming byte
  always_comb begin
    mark_match = (in_char_q == mark_char(MarkIdxW'(LookLen)));
    for (int i = 0; i < LookLen; i++) begin
      if (la_q[i] != mark_char(MarkIdxW'(i))) begin
        mark_match = 1'b0;
      end
    end
  end

  assign dec_head = rotate_letter(la_q[0], bwd_amt);
  assign can_load = !out_valid_q || m_axis_tready;

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BURST_IDLE;
      mark_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      mark_idx_q <= mark_idx_d;
    end
  end

  // Resolve the held item or the next burst result
  always_comb begin
    state_d    = state_q;
    mark_idx_d = mark_idx_q;
    in_take    = 1'b0;
    emit       = 1'b0;
    e_char     = TERM_CHAR;
    e_last     = 1'b0;
    e_status   = STATUS_OK;
    e_count    = '0;
    do_adv     = 1'b0;
    do_clear   = 1'b0;
    la_shift   = 1'b0;
    la_wr      = 1'b0;
    seen_d     = seen_q;
    fill_d     = fill_q;

    unique case (state_q)
      BURST_IDLE: begin
        if (in_valid_q) begin
          if (mode_q == MODE_ENC) begin
            if (!in_eot_q) begin
              // drop characters beyond the payload room
              if (cap_small || payload_full) begin
                in_take = 1'b1;
              end else if (can_load) begin
                in_take = 1'b1;
                emit    = 1'b1;
                e_char  = rotate_letter(in_char_q, fwd_amt);
                do_adv  = 1'b1;
              end
            end else if (can_load) begin
              in_take = 1'b1;
              emit    = 1'b1;
              if (cap_small) begin
                e_last   = 1'b1;
                e_status = STATUS_SMALL;
                do_clear = 1'b1;
              end else begin
                e_char     = mark_char('0);
                mark_idx_d = MarkIdxW'(1);
                state_d    = BURST_MARK;
              end
            end
          end else if (seen_q) begin
            // ignore the rest of a message after its marker
            in_take  = 1'b1;
            do_clear = in_eot_q;
          end else if (in_eot_q) begin
            if (can_load) begin
              in_take = 1'b1;
              emit    = 1'b1;
              if (fill_q == '0) begin
                e_last   = 1'b1;
                e_status = STATUS_MISSING;
                e_count  = shown;
                do_clear = 1'b1;
              end else begin
                e_char   = dec_head;
                la_shift = 1'b1;
                fill_d   = fill_q - FillW'(1);
                do_adv   = 1'b1;
                state_d  = BURST_FLUSH;
              end
            end
          end else if (fill_q == FillW'(LookLen)) begin
            if (can_load) begin
              in_take = 1'b1;
              emit    = 1'b1;
              if (mark_match) begin
                e_last   = 1'b1;
                e_count  = shown;
                do_clear = 1'b1;
                seen_d   = 1'b1;
              end else begin
                e_char   = dec_head;
                la_shift = 1'b1;
                do_adv   = 1'b1;
              end
            end
          end else begin
            // fill the lookahead
            in_take = 1'b1;
            la_wr   = 1'b1;
            fill_d  = fill_q + FillW'(1);
          end
        end
      end
      BURST_MARK: begin
        if (can_load) begin
          emit = 1'b1;
          if (mark_idx_q == MarkIdxW'(MarkLen)) begin
            e_last   = 1'b1;
            e_count  = shown;
            do_clear = 1'b1;
            state_d  = BURST_IDLE;
          end else begin
            e_char     = mark_char(mark_idx_q);
            mark_idx_d = mark_idx_q + MarkIdxW'(1);
          end
        end
      end
      BURST_FLUSH: begin
        if (can_load) begin
          emit = 1'b1;
          if (fill_q == '0) begin
            e_last   = 1'b1;
            e_status = STATUS_MISSING;
            e_count  = shown;
            do_clear = 1'b1;
            state_d  = BURST_IDLE;
          end else begin
            e_char   = dec_head;
            la_shift = 1'b1;
            fill_d   = fill_q - FillW'(1);
            do_adv   = 1'b1;
          end
        end
      end
      default: state_d = BURST_IDLE;
    endcase

    // advance position and count, then let a clear override
    byte_count_d = byte_count_q;
    pos_d        = pos_q;
    if (do_adv) begin
      if (byte_count_q != MaxCnt) begin
        byte_count_d = byte_count_q + CW'(1);
      end
      pos_d = (pos_q == ALPHA_LEN - KeyW'(1)) ? '0 : pos_q + PosW'(1);
    end
    if (do_clear) begin
      byte_count_d = '0;
      pos_d        = '0;
      fill_d       = '0;
      seen_d       = seen_d && !in_eot_q && (state_q == BURST_IDLE) && (mode_q == MODE_DEC);
    end
  end

  // Message state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      pos_q        <= '0;
      fill_q       <= '0;
      seen_q       <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      pos_q        <= pos_d;
      fill_q       <= fill_d;
      seen_q       <= seen_d;
    end
  end

  // Lookahead: append at the fill point or shift toward the head
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LookLen; i++) begin
      if (la_shift) begin
        la_q[i] <= (i == LookLen - 1) ? in_char_q : la_q[(i + 1) % LookLen];
      end else if (la_wr && (fill_q == FillW'(i))) begin
        la_q[i] <= in_char_q;
      end
    end
  end

  // Input register: take a new item whenever the held one resolves
  assign s_axis_tready = !in_valid_q || in_take;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (in_take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q   <= e_char;
      out_last_q   <= e_last;
      out_status_q <= e_status;
      out_count_q  <= e_count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_char_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the progressive Caesar codec result stream.
// ----------------------------------------------------------------------------
`include "progressive_caesar_codec_macros.svh"

module pcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);
  import pcc_pkg::*;

  // Hold a stalled result
  `PCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

  // Only the final result of a message carries status and count
  `PCC_ASSERT_SAME(a_mid_clean, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == STATUS_OK && m_axis_tdata[23:8] == '0)

  // Status code stays in its defined range
  `PCC_ASSERT_SAME(a_status_range, m_axis_tvalid, m_axis_tuser != 2'd3)

  // A too-small capacity ends the message with an empty terminator
  `PCC_ASSERT_SAME(a_small_term, m_axis_tvalid && m_axis_tuser == STATUS_SMALL, m_axis_tlast && m_axis_tdata == '0)

endmodule

bind progressive_caesar_codec pcc_checker u_pcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
